// ----- hdl/bdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and codes of the bounded deque
// Holds the request and response payload types, the request and status
// codes, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// Default number of entries in the store.
	localparam int CAPACITY_DEF = 32;

	// Request codes.
	localparam logic [3:0] REQ_ADD_FRONT  = 4'd0;
	localparam logic [3:0] REQ_ADD_BACK   = 4'd1;
	localparam logic [3:0] REQ_DEL_FRONT  = 4'd2;
	localparam logic [3:0] REQ_DEL_BACK   = 4'd3;
	localparam logic [3:0] REQ_REMOVE_VAL = 4'd4;
	localparam logic [3:0] REQ_CLEAR      = 4'd5;
	localparam logic [3:0] REQ_READ_ALL   = 4'd6;
	localparam logic [3:0] REQ_READ_FIRST = 4'd7;
	localparam logic [3:0] REQ_READ_LAST  = 4'd8;

	// Response status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One request transfer.
	typedef struct packed {
		logic        [3:0]  req_type;
		logic signed [31:0] operand;
	} req_t;

	// One response transfer.
	typedef struct packed {
		logic signed [31:0] item_value;
		logic               item_valid;
		logic        [1:0]  status;
		logic               last_item;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_req;    // capture the accepted request
		logic walk_init;   // set up a read or remove walk
		logic single_rsp;  // apply the update and load the single response
		logic rd_load;     // load one entry into the response register
		logic rm_step;     // one step of the remove-by-value walk
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;     // captured request is one of the reads
		logic is_remove;   // captured request is remove by value
		logic rd_nz;       // the read yields at least one entry
		logic rd_last;     // the current read entry is the final one
		logic rm_more;     // entries remain to be fetched by the remove walk
		logic rm_pend;     // a fetched entry is still being compared
		logic out_free;    // the response register can take a new result
	} stat_t;

endpackage

// ----- hdl/bdq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_ctrl: sequencing state machine of the bounded deque
// Accepts one request at a time and steps the datapath through the single
// response, the entry read walk or the remove-by-value walk.
// ----------------------------------------------------------------------------
module bdq_ctrl
	import bdq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  busy,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_EXEC    = 6'b000010,
		S_RD_ADDR = 6'b000100,
		S_RD_LOAD = 6'b001000,
		S_RM_RUN  = 6'b010000,
		S_RESP    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// A new request is taken only while no other is in progress.
	assign busy = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_remove) begin
					cmd.walk_init = 1'b1;
					state_d       = S_RM_RUN;
				end else if (stat.is_read && stat.rd_nz) begin
					cmd.walk_init = 1'b1;
					state_d       = S_RD_ADDR;
				end else begin
					state_d = S_RESP;
				end
			end
			S_RD_ADDR: begin
				// The store read data becomes valid after this cycle.
				state_d = S_RD_LOAD;
			end
			S_RD_LOAD: begin
				if (stat.out_free) begin
					cmd.rd_load = 1'b1;
					state_d     = stat.rd_last ? S_IDLE : S_RD_ADDR;
				end
			end
			S_RM_RUN: begin
				if (stat.rm_more || stat.rm_pend) begin
					cmd.rm_step = 1'b1;
				end else begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.single_rsp = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// A request is captured only from the idle state.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_req |-> state_q == S_IDLE)
		else $error("request captured while busy");

	// Response loads never overlap one another.
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_load && cmd.single_rsp))
		else $error("two response loads in one cycle");

	// After a single response the controller is idle again.
	a_resp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.single_rsp |=> state_q == S_IDLE)
		else $error("controller not idle after single response");
`endif

endmodule

// ----- hdl/bdq_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdq_dpath: storage and datapath of the bounded deque
// Circular entry store with registered read, front position and entry
// count, walk counters for reads and remove by value, and the response
// output register.
// ----------------------------------------------------------------------------
module bdq_dpath
	import bdq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output rsp_t  rsp,
	output logic  rsp_valid,
	input  logic  rsp_stall
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W:0]   CAP_X   = (CNT_W + 1)'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

	// Entry store, never cleared.
	logic [31:0] mem [CAPACITY];
	logic signed [31:0] rdata_q;

	// Control state.
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] kept_q;
	logic [CNT_W-1:0] start_q;
	logic [CNT_W-1:0] n_q;
	logic             rm_vld_s1;
	logic             rsp_valid_q;

	// Payload registers.
	req_t req_q;
	rsp_t rsp_q;

	logic             full;
	logic             empty;
	logic [CNT_W-1:0] n_clamp;
	logic [1:0]       sgl_status;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_data;
	logic             rm_keep;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;

	// Physical slot of logical position x counted from the front.
	function automatic logic [IDX_W-1:0] slot_of(
		input logic [IDX_W-1:0] front,
		input logic [CNT_W:0]   x
	);
		logic [CNT_W:0] t;
		t = (CNT_W + 1)'(front) + x;
		if (t >= CAP_X) begin
			t = t - CAP_X;
		end
		return t[IDX_W-1:0];
	endfunction

	assign full  = (count_q == CAP_C);
	assign empty = (count_q == '0);

	assign front_dec = (front_q == '0) ? LAST_IX : front_q - 1'b1;
	assign front_inc = slot_of(front_q, (CNT_W + 1)'(1));

	// Clamp the read count: negative gives zero, above the count gives the count.
	always_comb begin
		if (req_q.operand[31]) begin
			n_clamp = '0;
		end else if (req_q.operand[30:0] > 31'(count_q)) begin
			n_clamp = count_q;
		end else begin
			n_clamp = req_q.operand[CNT_W-1:0];
		end
	end

	// Status of a request that gives one response without entries.
	always_comb begin
		unique case (req_q.req_type)
			REQ_ADD_FRONT,
			REQ_ADD_BACK:   sgl_status = full ? ST_FULL : ST_OK;
			REQ_DEL_FRONT,
			REQ_DEL_BACK,
			REQ_READ_ALL,
			REQ_READ_FIRST: sgl_status = empty ? ST_EMPTY : ST_OK;
			default:        sgl_status = ST_OK;
		endcase
	end

	// Status towards the controller.
	always_comb begin
		stat.is_read   = (req_q.req_type == REQ_READ_ALL) ||
		                 (req_q.req_type == REQ_READ_FIRST) ||
		                 (req_q.req_type == REQ_READ_LAST);
		stat.is_remove = (req_q.req_type == REQ_REMOVE_VAL);
		stat.rd_nz     = (req_q.req_type == REQ_READ_ALL) ? !empty : (n_clamp != '0);
		stat.rd_last   = ((CNT_W + 1)'(idx_q) + 1'b1) == (CNT_W + 1)'(n_q);
		stat.rm_more   = (idx_q < count_q);
		stat.rm_pend   = rm_vld_s1;
		stat.out_free  = !rsp_valid_q || !rsp_stall;
	end

	// Read address of the walk; the remove walk starts at the front.
	assign rd_addr = slot_of(front_q, (CNT_W + 1)'(start_q) + (CNT_W + 1)'(idx_q));

	// A fetched entry that differs from the operand is written back compacted.
	assign rm_keep = rm_vld_s1 && (rdata_q != req_q.operand);

	// Store write port selection.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_of(front_q, (CNT_W + 1)'(count_q));
		wr_data = req_q.operand;
		if (rm_keep) begin
			wr_en   = 1'b1;
			wr_addr = slot_of(front_q, (CNT_W + 1)'(kept_q));
			wr_data = rdata_q;
		end else if (cmd.single_rsp && !full) begin
			if (req_q.req_type == REQ_ADD_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = front_dec;
			end else if (req_q.req_type == REQ_ADD_BACK) begin
				wr_en = 1'b1;
			end
		end
	end

	// Entry store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			req_q <= req;
		end
	end

	// Front position, entry count and walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			kept_q    <= '0;
			start_q   <= '0;
			n_q       <= '0;
			rm_vld_s1 <= 1'b0;
		end else begin
			rm_vld_s1 <= cmd.rm_step && stat.rm_more;
			if (cmd.walk_init) begin
				idx_q  <= '0;
				kept_q <= '0;
				if (req_q.req_type == REQ_READ_LAST) begin
					start_q <= count_q - n_clamp;
				end else begin
					start_q <= '0;
				end
				n_q <= (req_q.req_type == REQ_READ_ALL) ? count_q : n_clamp;
			end
			if (cmd.rd_load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.rm_step && stat.rm_more) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rm_keep) begin
				kept_q <= kept_q + 1'b1;
			end
			if (cmd.single_rsp) begin
				case (req_q.req_type)
					REQ_ADD_FRONT: begin
						if (!full) begin
							front_q <= front_dec;
							count_q <= count_q + 1'b1;
						end
					end
					REQ_ADD_BACK: begin
						if (!full) begin
							count_q <= count_q + 1'b1;
						end
					end
					REQ_DEL_FRONT: begin
						if (!empty) begin
							front_q <= front_inc;
							count_q <= count_q - 1'b1;
						end
					end
					REQ_DEL_BACK: begin
						if (!empty) begin
							count_q <= count_q - 1'b1;
						end
					end
					REQ_REMOVE_VAL: begin
						count_q <= kept_q;
					end
					REQ_CLEAR: begin
						count_q <= '0;
						front_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Response register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.single_rsp || cmd.rd_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			rsp_q.item_value <= rdata_q;
			rsp_q.item_valid <= 1'b1;
			rsp_q.status     <= ST_OK;
			rsp_q.last_item  <= stat.rd_last;
		end else if (cmd.single_rsp) begin
			rsp_q.item_value <= '0;
			rsp_q.item_valid <= 1'b0;
			rsp_q.status     <= sgl_status;
			rsp_q.last_item  <= 1'b1;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

`ifndef SYNTHESIS
	// The entry count never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// Compaction never writes ahead of the fetch position.
	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= idx_q)
		else $error("remove walk kept count passed fetch index");

	// A response is loaded only when the register is free.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.single_rsp || cmd.rd_load) |-> (!rsp_valid_q || !rsp_stall))
		else $error("response overwritten while stalled");

	// A compaction write never lands on the slot being fetched.
	a_rm_no_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rm_keep && cmd.rm_step && stat.rm_more) |-> wr_addr != rd_addr)
		else $error("remove walk write clashes with fetch");
`endif

endmodule

// ----- hdl/bounded_deque_with_value_remove.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_value_remove: bounded double-ended queue
// Bounded ordered list of signed 32-bit words with inserts and deletes at
// both ends, remove by value with compaction, clear, and three reads.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_valid, req_stall   | req_t: req_type, operand
//   rsp     | out | rsp_valid, rsp_stall   | rsp_t: item_value, item_valid,
//           |     |                        |        status, last_item
//
// A command without entries to give is captured, executed, and then loaded
// into the response register. A read of N entries does one store read and
// one load of the response register for each entry.
// Remove by value fetches one entry a cycle through the single store read
// port and compares the last fetched entry before its response is loaded.
// Reset clears the count, the front position and the state machine; the
// entry store keeps its contents and needs no clearing pass.
// A stalled response holds the read walk until the register frees.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_remove
	import bdq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;
	logic  busy;

	// Sequencing.
	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.busy      (busy),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage and response register.
	bdq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	// Requests stall while a command is in progress.
	assign req_stall = busy;

endmodule
